/* sv/mexp_pkg.sv */
// Shared types and constants for the modular exponentiation block.
package mexp_pkg;

    localparam int DATA_W = 32;
    localparam logic [DATA_W-1:0] MODULUS_RESET = 32'd2;

    // Operand select for the modular multiplier
    localparam logic [1:0] MSEL_REDUCE = 2'd0;  // 1 * base, reduces the raw base
    localparam logic [1:0] MSEL_SQUARE = 2'd1;  // acc * acc
    localparam logic [1:0] MSEL_BASE   = 2'd2;  // acc * reduced base

    typedef struct packed {
        logic       load;
        logic       clear_acc;
        logic       mul_start;
        logic [1:0] mul_sel;
        logic       mul_step;
        logic       wb_base;
        logic       wb_acc;
        logic       exp_shift;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic n_small;
        logic exp_msb;
        logic mul_last;
        logic exp_last;
    } t_dp_status;

endpackage

/* sv/mexp_if.sv */
// Valid/ready channel interfaces for requests and results.
interface mexp_in_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::DATA_W-1:0] base_value;
    logic [mexp_pkg::DATA_W-1:0] exponent_value;

    modport source (output valid, output base_value, output exponent_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value, output ready);
endinterface

interface mexp_out_if;
    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::DATA_W-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* sv/mexp_dp.sv */
// Datapath: modulus register, operands, serial modular multiplier, result register.
module mexp_dp #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0] i_cfg_data,
    input  logic [mexp_pkg::DATA_W-1:0] i_base_value,
    input  logic [mexp_pkg::DATA_W-1:0] i_exponent_value,
    input  mexp_pkg::t_dp_cmd           i_cmd,
    output mexp_pkg::t_dp_status        o_status,
    output logic [mexp_pkg::DATA_W-1:0] o_power_result
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(OPERAND_WIDTH);
    localparam logic [CW-1:0] LAST_BIT = CW'(OPERAND_WIDTH - 1);

    logic [mexp_pkg::DATA_W-1:0] r_modulus;
    logic [W-1:0]  r_base, r_exp, r_acc, r_result;
    logic [W-1:0]  r_ma, r_mb, r_macc;
    logic [CW-1:0] r_bit_cnt, r_exp_cnt;

    logic [W-1:0]  w_n;
    logic          w_n_small;
    logic [W-1:0]  w_sel_a, w_sel_b;
    logic [W+1:0]  w_sum, w_n1, w_n2, w_red;
    logic [W-1:0]  w_mac_next;

    assign w_n       = W'(r_modulus);
    assign w_n_small = (w_n < W'(2));

    // One multiplier bit per cycle: 2*acc + a*bit stays below 3n,
    // so one of three candidates is the reduced value.
    assign w_sum = {1'b0, r_macc, 1'b0} + {2'b00, (r_mb[W-1] ? r_ma : '0)};
    assign w_n1  = {2'b00, w_n};
    assign w_n2  = {1'b0, w_n, 1'b0};

    always_comb begin
        if (w_sum >= w_n2) begin
            w_red = w_sum - w_n2;
        end else if (w_sum >= w_n1) begin
            w_red = w_sum - w_n1;
        end else begin
            w_red = w_sum;
        end
    end
    assign w_mac_next = w_red[W-1:0];

    always_comb begin
        case (i_cmd.mul_sel)
            mexp_pkg::MSEL_REDUCE: begin
                w_sel_a = W'(1);
                w_sel_b = r_base;
            end
            mexp_pkg::MSEL_SQUARE: begin
                w_sel_a = r_acc;
                w_sel_b = r_acc;
            end
            mexp_pkg::MSEL_BASE: begin
                w_sel_a = r_acc;
                w_sel_b = r_base;
            end
            default: begin
                w_sel_a = '0;
                w_sel_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MODULUS_RESET;
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base    <= W'(i_base_value);
            r_exp     <= W'(i_exponent_value);
            r_acc     <= W'(1);
            r_exp_cnt <= LAST_BIT;
        end
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end
        if (i_cmd.mul_start) begin
            r_ma      <= w_sel_a;
            r_mb      <= w_sel_b;
            r_macc    <= '0;
            r_bit_cnt <= LAST_BIT;
        end
        if (i_cmd.mul_step) begin
            r_macc    <= w_mac_next;
            r_mb      <= r_mb << 1;
            r_bit_cnt <= r_bit_cnt - CW'(1);
        end
        if (i_cmd.wb_base) begin
            r_base <= w_mac_next;
        end
        if (i_cmd.wb_acc) begin
            r_acc <= w_mac_next;
        end
        if (i_cmd.exp_shift) begin
            r_exp     <= r_exp << 1;
            r_exp_cnt <= r_exp_cnt - CW'(1);
        end
        if (i_cmd.out_load) begin
            r_result <= r_acc;
        end
    end

    assign o_status.n_small  = w_n_small;
    assign o_status.exp_msb  = r_exp[W-1];
    assign o_status.mul_last = (r_bit_cnt == '0);
    assign o_status.exp_last = (r_exp_cnt == '0);
    assign o_power_result    = mexp_pkg::DATA_W'(r_result);

    // Multiplier accumulator stays reduced while stepping
    a_macc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_step && !w_n_small |=> r_macc < w_n)
        else $error("multiplier accumulator not below modulus");

    // A loaded result is reduced
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && !w_n_small |=> r_result < $past(w_n))
        else $error("result not below modulus");

    // Modulus below two gives zero
    a_small_mod_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && w_n_small |=> r_result == '0)
        else $error("nonzero result for modulus below two");

endmodule

/* sv/mexp_ctrl.sv */
// Controller: sequences base reduction, square and multiply steps, and result handoff.
module mexp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  mexp_pkg::t_dp_status i_status,
    output mexp_pkg::t_dp_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;
    localparam logic [3:0] S_RED      = 4'd2;
    localparam logic [3:0] S_SQ_START = 4'd3;
    localparam logic [3:0] S_SQ       = 4'd4;
    localparam logic [3:0] S_MB_START = 4'd5;
    localparam logic [3:0] S_MB       = 4'd6;
    localparam logic [3:0] S_NEXT     = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.n_small) begin
                    o_cmd.clear_acc = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = mexp_pkg::MSEL_REDUCE;
                    n_state         = S_RED;
                end
            end
            S_RED: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.wb_base = 1'b1;
                    n_state       = S_SQ_START;
                end
            end
            S_SQ_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mexp_pkg::MSEL_SQUARE;
                n_state         = S_SQ;
            end
            S_SQ: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.wb_acc = 1'b1;
                    n_state      = i_status.exp_msb ? S_MB_START : S_NEXT;
                end
            end
            S_MB_START: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = mexp_pkg::MSEL_BASE;
                n_state         = S_MB;
            end
            S_MB: begin
                o_cmd.mul_step = 1'b1;
                if (i_status.mul_last) begin
                    o_cmd.wb_acc = 1'b1;
                    n_state      = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.exp_shift = 1'b1;
                n_state         = i_status.exp_last ? S_FINISH : S_SQ_START;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // Busy right after taking a request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after request accept");

    // Result register never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_out_valid || i_out_ready)
        else $error("pending result overwritten");

endmodule

/* sv/modular_exponentiation.sv */
// Top level: modular exponentiation (square and multiply) with one config register.
// One request is computed at a time; the bit-serial modular multiplier takes one
// multiplier bit per cycle. The next request is accepted once the finished
// result is in the output register.
// Reset (synchronous, active low) sets modulus to 2 and idles the controller.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0] i_cfg_data,
    mexp_in_if.sink                     i_in,
    mexp_out_if.source                  o_out
);

    mexp_pkg::t_dp_cmd    w_cmd;
    mexp_pkg::t_dp_status w_status;

    // Controller: request handshake, step sequencing, result valid flag.
    // A finished result parks in the output register so the next request
    // can be accepted while the result waits downstream.
    mexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: base reduced first (Horner pass of 1 * base), then per
    // exponent bit a square and, on a one bit, a multiply by the base.
    mexp_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_base_value     (i_in.base_value),
        .i_exponent_value (i_in.exponent_value),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_power_result   (o_out.power_result)
    );

endmodule
